@@ hdl/smx_pkg.sv @@
package smx_pkg;

    localparam int DATA_W              = 32;
    localparam int STACK_DEPTH_DEFAULT = 256;

    // Instruction codes
    localparam logic [3:0] FUNC_LOAD = 4'd0;
    localparam logic [3:0] FUNC_PUSH = 4'd1;
    localparam logic [3:0] FUNC_POP  = 4'd2;
    localparam logic [3:0] FUNC_ADD  = 4'd3;
    localparam logic [3:0] FUNC_SUB  = 4'd4;
    localparam logic [3:0] FUNC_MUL  = 4'd5;
    localparam logic [3:0] FUNC_DIV  = 4'd6;
    localparam logic [3:0] FUNC_OUT  = 4'd7;
    localparam logic [3:0] FUNC_END  = 4'd8;

    // Fault codes
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_OVER  = 2'd1;
    localparam logic [1:0] FAULT_UNDER = 2'd2;
    localparam logic [1:0] FAULT_DIV0  = 2'd3;

    typedef struct packed {
        logic [3:0]               func;
        logic signed [DATA_W-1:0] immediate;
    } in_item_t;

    typedef struct packed {
        logic                     emitted;
        logic signed [DATA_W-1:0] emitted_value;
        logic [1:0]               fault;
    } out_item_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_DIVIDE,
        ALU_FINISH
    } alu_state_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_FETCH,
        SEQ_EXEC,
        SEQ_RESP
    } seq_state_t;

endpackage

@@ hdl/stack_machine_executor.sv @@
// Load, push, pop, out, end and a divide by zero are handled in fetch; add, sub, mul and div
// wait in execute for the arithmetic unit, div forming one quotient bit per cycle. A new
// request is taken only once the last result is loaded; a stalled result holds the block.
// Reset: synchronous active-low clears state, top index, work register, slot-0 written flag and output valid.
// The stack memory is not swept: slot 0 carries a written flag, deeper slots are read
// only after a push has written them, so no clearing pass follows reset.
module stack_machine_executor #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  smx_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output smx_pkg::out_item_t  m_item
);

    localparam int W  = smx_pkg::DATA_W;
    localparam int AW = $clog2(STACK_DEPTH);

    smx_pkg::seq_state_t state_reg, state_next;
    smx_pkg::in_item_t   item_reg, item_next;
    smx_pkg::out_item_t  res_reg, res_next;
    smx_pkg::out_item_t  m_item_reg, m_item_next;
    logic [AW-1:0]       top_index_reg, top_index_next;
    logic [W-1:0]        work_reg, work_next;
    logic                scratch_valid_reg, scratch_valid_next;
    logic                m_valid_reg, m_valid_next;

    smx_pkg::alu_req_t   alu_req;
    logic                alu_done;
    logic [W-1:0]        alu_result;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [W-1:0]        wr_data;
    logic                rd_en;
    logic [W-1:0]        rd_data;
    logic [W-1:0]        operand;

    // Stack store
    smx_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (top_index_reg),
        .rd_data (rd_data)
    );

    // Shared arithmetic unit
    smx_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (operand),
        .opb     (work_reg),
        .done    (alu_done),
        .result  (alu_result)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= smx_pkg::SEQ_IDLE;
            top_index_reg     <= '0;
            work_reg          <= '0;
            scratch_valid_reg <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            top_index_reg     <= top_index_next;
            work_reg          <= work_next;
            scratch_valid_reg <= scratch_valid_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

    // Top entry; slot 0 reads as zero until arithmetic has written it
    assign operand = (top_index_reg == '0 && !scratch_valid_reg) ? '0 : rd_data;

    assign s_ready = (state_reg == smx_pkg::SEQ_IDLE);
    assign rd_en   = s_valid && s_ready;

    // Sequencer
    always_comb begin
        state_next         = state_reg;
        item_next          = item_reg;
        res_next           = res_reg;
        top_index_next     = top_index_reg;
        work_next          = work_reg;
        scratch_valid_next = scratch_valid_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_item_next        = m_item_reg;
        alu_req.start      = 1'b0;
        alu_req.op         = smx_pkg::ALU_ADD;
        wr_en              = 1'b0;
        wr_addr            = top_index_reg;
        wr_data            = alu_result;
        case (state_reg)
            smx_pkg::SEQ_IDLE: begin
                if (s_valid) begin
                    item_next  = s_item;
                    state_next = smx_pkg::SEQ_FETCH;
                end
            end
            smx_pkg::SEQ_FETCH: begin
                res_next.emitted       = 1'b0;
                res_next.emitted_value = '0;
                res_next.fault         = smx_pkg::FAULT_NONE;
                state_next             = smx_pkg::SEQ_RESP;
                case (item_reg.func)
                    smx_pkg::FUNC_LOAD: begin
                        work_next = item_reg.immediate;
                    end
                    smx_pkg::FUNC_PUSH: begin
                        if (top_index_reg == AW'(STACK_DEPTH - 1)) begin
                            res_next.fault = smx_pkg::FAULT_OVER;
                        end else begin
                            wr_en          = 1'b1;
                            wr_addr        = top_index_reg + AW'(1);
                            wr_data        = work_reg;
                            top_index_next = top_index_reg + AW'(1);
                        end
                    end
                    smx_pkg::FUNC_POP: begin
                        if (top_index_reg == '0) begin
                            res_next.fault = smx_pkg::FAULT_UNDER;
                        end else begin
                            work_next      = operand;
                            top_index_next = top_index_reg - AW'(1);
                        end
                    end
                    smx_pkg::FUNC_ADD: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = smx_pkg::ALU_ADD;
                        state_next    = smx_pkg::SEQ_EXEC;
                    end
                    smx_pkg::FUNC_SUB: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = smx_pkg::ALU_SUB;
                        state_next    = smx_pkg::SEQ_EXEC;
                    end
                    smx_pkg::FUNC_MUL: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = smx_pkg::ALU_MUL;
                        state_next    = smx_pkg::SEQ_EXEC;
                    end
                    smx_pkg::FUNC_DIV: begin
                        if (work_reg == '0) begin
                            res_next.fault = smx_pkg::FAULT_DIV0;
                        end else begin
                            alu_req.start = 1'b1;
                            alu_req.op    = smx_pkg::ALU_DIV;
                            state_next    = smx_pkg::SEQ_EXEC;
                        end
                    end
                    smx_pkg::FUNC_OUT: begin
                        res_next.emitted       = 1'b1;
                        res_next.emitted_value = work_reg;
                    end
                    default: begin
                        // End and unused codes change nothing
                    end
                endcase
            end
            smx_pkg::SEQ_EXEC: begin
                // Write the result back to the top entry
                if (alu_done) begin
                    wr_en   = 1'b1;
                    wr_addr = top_index_reg;
                    wr_data = alu_result;
                    if (top_index_reg == '0) begin
                        scratch_valid_next = 1'b1;
                    end
                    state_next = smx_pkg::SEQ_RESP;
                end
            end
            smx_pkg::SEQ_RESP: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = res_reg;
                    state_next   = smx_pkg::SEQ_IDLE;
                end
            end
            default: begin
                state_next = smx_pkg::SEQ_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Top index moves only while an instruction is fetched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != smx_pkg::SEQ_FETCH) |=> $stable(top_index_reg))
        else $error("top index changed outside fetch");

    // The arithmetic unit finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> (state_reg == smx_pkg::SEQ_EXEC))
        else $error("arithmetic result with no waiting instruction");

    // An emitted value never carries a fault
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.emitted) |-> (m_item.fault == smx_pkg::FAULT_NONE))
        else $error("emitted result with fault");

    // Value is zero when nothing is emitted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.emitted) |-> (m_item.emitted_value == '0))
        else $error("nonzero value without emit");

    // A new request is taken only after the previous result is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == smx_pkg::SEQ_RESP && m_valid_reg && !m_ready)
        |=> (state_reg == smx_pkg::SEQ_RESP))
        else $error("result dropped while output stalled");

endmodule

@@ hdl/smx_stack_ram.sv @@
module smx_stack_ram #(
    parameter int DEPTH = smx_pkg::STACK_DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [smx_pkg::DATA_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [smx_pkg::DATA_W-1:0] rd_data
);

    logic [smx_pkg::DATA_W-1:0] mem [DEPTH];
    logic [smx_pkg::DATA_W-1:0] rd_data_reg;

    // Write one word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/smx_alu.sv @@
module smx_alu (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  smx_pkg::alu_req_t          req,
    input  logic [smx_pkg::DATA_W-1:0] opa,
    input  logic [smx_pkg::DATA_W-1:0] opb,
    output logic                       done,
    output logic [smx_pkg::DATA_W-1:0] result
);

    localparam int W  = smx_pkg::DATA_W;
    localparam int CW = $clog2(W);

    smx_pkg::alu_state_t state_reg, state_next;
    logic [W-1:0]  result_reg, result_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dmag_reg, dmag_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] count_reg, count_next;

    logic [W:0]    rem_shift;
    logic          step_ge;
    logic [W:0]    step_diff;
    logic [W-1:0]  quo_step;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= smx_pkg::ALU_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        result_reg <= result_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dmag_reg   <= dmag_next;
        neg_reg    <= neg_next;
    end

    // One restoring division step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_shift = {rem_reg, quo_reg[W-1]};
        step_ge   = (rem_shift >= {1'b0, dmag_reg});
        step_diff = rem_shift - {1'b0, dmag_reg};
        quo_step  = {quo_reg[W-2:0], step_ge};
    end

    // Sequence the operation
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        result_next = result_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dmag_next   = dmag_reg;
        neg_next    = neg_reg;
        case (state_reg)
            smx_pkg::ALU_IDLE: begin
                if (req.start) begin
                    case (req.op)
                        smx_pkg::ALU_ADD: begin
                            result_next = opa + opb;
                            state_next  = smx_pkg::ALU_FINISH;
                        end
                        smx_pkg::ALU_SUB: begin
                            result_next = opa - opb;
                            state_next  = smx_pkg::ALU_FINISH;
                        end
                        smx_pkg::ALU_MUL: begin
                            result_next = opa * opb;
                            state_next  = smx_pkg::ALU_FINISH;
                        end
                        default: begin
                            // Divide on magnitudes, fix the sign at the end
                            rem_next   = '0;
                            quo_next   = opa[W-1] ? (W'(0) - opa) : opa;
                            dmag_next  = opb[W-1] ? (W'(0) - opb) : opb;
                            neg_next   = opa[W-1] ^ opb[W-1];
                            count_next = '0;
                            state_next = smx_pkg::ALU_DIVIDE;
                        end
                    endcase
                end
            end
            smx_pkg::ALU_DIVIDE: begin
                rem_next   = step_ge ? step_diff[W-1:0] : rem_shift[W-1:0];
                quo_next   = quo_step;
                count_next = count_reg + CW'(1);
                if (count_reg == CW'(W - 1)) begin
                    result_next = neg_reg ? (W'(0) - quo_step) : quo_step;
                    state_next  = smx_pkg::ALU_FINISH;
                end
            end
            smx_pkg::ALU_FINISH: begin
                state_next = smx_pkg::ALU_IDLE;
            end
            default: begin
                state_next = smx_pkg::ALU_IDLE;
            end
        endcase
    end

    assign done   = (state_reg == smx_pkg::ALU_FINISH);
    assign result = result_reg;

endmodule
